@@ rtl/cfq_pkg.sv @@
// Shared types and codes of the circular FIFO queue.
package cfq_pkg;

    // Operation codes carried by each input item.
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_PUSH  = 2'd0;
    localparam t_opcode OP_POP   = 2'd1;
    localparam t_opcode OP_PEEK  = 2'd2;
    localparam t_opcode OP_CLEAR = 2'd3;

    // Widths fixed by the item format.
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 7;
    localparam int CFG_W    = 8;

    // Outcome of one operation, from the ring control to the result stages.
    typedef struct packed {
        logic             success;
        logic             rd_req;
        logic             is_empty;
        logic             is_full;
        logic [OCC_W-1:0] occupancy;
    } t_status;

endpackage

@@ rtl/cfq_channels.sv @@
// Request and response channel interfaces of the circular FIFO queue.
interface cfq_req_if;
    logic                             valid;
    logic                             ready;
    cfq_pkg::t_opcode                 opcode;
    logic signed [cfq_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface cfq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              success;
    logic signed [cfq_pkg::WORD_W-1:0] read_value;
    logic [cfq_pkg::OCC_W-1:0]         occupancy;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output success, output read_value, output occupancy,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input success, input read_value, input occupancy,
                    input is_empty, input is_full, output ready);
endinterface

@@ rtl/cfq_slot_ram.sv @@
// Slot storage: one write port, one read port, registered read data.
module cfq_slot_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [cfq_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [cfq_pkg::WORD_W-1:0] o_rd_data
);

    logic [cfq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [cfq_pkg::WORD_W-1:0] r_rd_data;

    // Store pushed words.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the head word; hold it until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/cfq_ring_ctrl.sv @@
// Head, tail and ring size registers, and the per-operation index update.
module cfq_ring_ctrl #(
    parameter int MAX_SLOTS = 128,
    parameter int IW        = 7,
    parameter int CW        = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cfq_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    input  cfq_pkg::t_opcode          i_opcode,
    output logic                      o_wr_en,
    output logic [IW-1:0]             o_wr_addr,
    output logic                      o_rd_en,
    output logic [IW-1:0]             o_rd_addr,
    output cfq_pkg::t_status          o_status
);

    localparam int RST_SLOTS = (128 > MAX_SLOTS) ? MAX_SLOTS : 128;
    localparam int CMP_W     = (CW > cfq_pkg::CFG_W) ? CW : cfq_pkg::CFG_W;

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_slot_count, n_slot_count;

    logic          empty_now;
    logic          full_now;
    logic [CW-1:0] fill;
    logic [CMP_W-1:0] cfg_wide;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cnt);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cnt) ? '0 : IW'(inc);
    endfunction

    // Flags before the operation.
    assign empty_now = (r_head == r_tail);
    assign full_now  = (wrap_next(r_tail, r_slot_count) == r_head);

    // Saturate the written ring size into the legal range.
    assign cfg_wide = CMP_W'(i_cfg_data);
    always_comb begin
        if (cfg_wide < CMP_W'(2)) begin
            n_slot_count = CW'(2);
        end else if (cfg_wide > CMP_W'(MAX_SLOTS)) begin
            n_slot_count = CW'(MAX_SLOTS);
        end else begin
            n_slot_count = CW'(cfg_wide);
        end
    end

    // Decode the operation, advance the indices and report the state after it.
    always_comb begin
        n_head           = r_head;
        n_tail           = r_tail;
        o_wr_en          = 1'b0;
        o_rd_en          = 1'b0;
        o_status.success = 1'b0;
        o_status.rd_req  = 1'b0;
        case (i_opcode)
            cfq_pkg::OP_PUSH: begin
                if (!full_now) begin
                    o_wr_en          = i_accept;
                    n_tail           = wrap_next(r_tail, r_slot_count);
                    o_status.success = 1'b1;
                end
            end
            cfq_pkg::OP_POP: begin
                if (!empty_now) begin
                    o_rd_en          = i_accept;
                    n_head           = wrap_next(r_head, r_slot_count);
                    o_status.success = 1'b1;
                    o_status.rd_req  = 1'b1;
                end
            end
            cfq_pkg::OP_PEEK: begin
                if (!empty_now) begin
                    o_rd_en          = i_accept;
                    o_status.success = 1'b1;
                    o_status.rd_req  = 1'b1;
                end
            end
            default: begin
                n_head           = '0;
                n_tail           = '0;
                o_status.success = 1'b1;
            end
        endcase
        fill = (n_tail >= n_head) ? (CW'(n_tail) - CW'(n_head))
                                  : (CW'(n_tail) + r_slot_count - CW'(n_head));
        o_status.occupancy = cfq_pkg::OCC_W'(fill);
        o_status.is_empty  = (n_head == n_tail);
        o_status.is_full   = (wrap_next(n_tail, r_slot_count) == n_head);
    end

    assign o_wr_addr = r_tail;
    assign o_rd_addr = r_head;

    // Hold the indices; a ring size write also empties the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_slot_count <= CW'(RST_SLOTS);
        end else if (i_cfg_we) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_slot_count <= n_slot_count;
        end else if (i_accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

endmodule

@@ rtl/circular_fifo_queue.sv @@
// Top level of the circular FIFO queue: ring control, slot memory and result stages.
// Each request item (push, pop, peek or clear) yields one response item once it is
// accepted, and a new item is accepted every cycle while responses are taken:
// indices update in the accept cycle, the slot memory read data is registered,
// and the response waits in an output register. The ring holds MAX_SLOTS words of
// storage; the written slot count (saturated to 2..MAX_SLOTS) sets the wrap point,
// one slot stays unused, and every slot count write empties the queue.
module circular_fifo_queue #(
    parameter int MAX_SLOTS = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cfq_pkg::CFG_W-1:0] i_cfg_data,
    cfq_req_if.sink                   i_req,
    cfq_rsp_if.source                 o_rsp
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic                       accept;
    logic                       s1_adv;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic [cfq_pkg::WORD_W-1:0] rd_data;
    cfq_pkg::t_status           status;

    logic                       r_s1_valid;
    cfq_pkg::t_status           r_s1_status;
    logic                       r_out_valid;
    cfq_pkg::t_status           r_out_status;
    logic [cfq_pkg::WORD_W-1:0] r_out_value;

    // Handshake: the read stage moves on when the output register is empty or its item is being taken.
    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    cfq_ring_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_opcode   (i_req.opcode),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_status   (status)
    );

    cfq_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Track the item whose memory read is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= status;
        end
    end

    // Hold the finished item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_value  <= r_s1_status.rd_req ? rd_data : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.success    = r_out_status.success;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.occupancy  = r_out_status.occupancy;
    assign o_rsp.is_empty   = r_out_status.is_empty;
    assign o_rsp.is_full    = r_out_status.is_full;

endmodule

@@ dv/tb_circular_fifo_queue.sv @@
// Self-checking testbench of the circular FIFO queue: directed table, then random phases.
`timescale 1ns / 1ps

module tb_circular_fifo_queue;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RING_MAX      = 128;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 220;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;

    // Fields of one response item, as the predictor computes them.
    typedef struct packed {
        logic                       success;
        logic [cfq_pkg::WORD_W-1:0] read_value;
        logic [cfq_pkg::OCC_W-1:0]  occupancy;
        logic                       is_empty;
        logic                       is_full;
    } t_result;

    typedef enum logic {ROW_OP, ROW_CFG} t_row_kind;

    // One row of the directed table: an item, or a slot count write.
    typedef struct packed {
        t_row_kind                  kind;
        cfq_pkg::t_opcode           op;
        logic [cfq_pkg::WORD_W-1:0] value;
        logic [cfq_pkg::CFG_W-1:0]  cfg_value;
        logic                       has_want;
        t_result                    want;
    } t_row;

    localparam t_result NO_WANT = '0;
    localparam int DIR_ROWS = 26;

    localparam t_row DIRECTED [DIR_ROWS] = '{
        // empty ring after reset
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b0, 32'h0,        7'd0, 1'b1, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PEEK,  32'h0,        8'd0,   1'b1,
          '{1'b0, 32'h0,        7'd0, 1'b1, 1'b0}},
        // word extremes
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h80000000, 8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd1, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h7FFFFFFF, 8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd2, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'hFFFFFFFF, 8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd3, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h00000000, 8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd4, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PEEK,  32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h80000000, 7'd4, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h80000000, 7'd3, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h7FFFFFFF, 7'd2, 1'b0, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_CLEAR, 32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd0, 1'b1, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b0, 32'h0,        7'd0, 1'b1, 1'b0}},
        // slot count below range saturates to two: one usable entry
        '{ROW_CFG, cfq_pkg::OP_PUSH,  32'h0,        8'd0,   1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h55555555, 8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd1, 1'b0, 1'b1}},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'hAAAAAAAA, 8'd0,   1'b1,
          '{1'b0, 32'h0,        7'd1, 1'b0, 1'b1}},
        '{ROW_OP,  cfq_pkg::OP_PEEK,  32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h55555555, 7'd1, 1'b0, 1'b1}},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h55555555, 7'd0, 1'b1, 1'b0}},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h12345678, 8'd0,   1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'h00000001, 8'd0,   1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_CLEAR, 32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd0, 1'b1, 1'b0}},
        // slot count above range saturates; a write to a busy ring empties it
        '{ROW_CFG, cfq_pkg::OP_PUSH,  32'h0,        8'd255, 1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_PUSH,  32'hDEADBEEF, 8'd0,   1'b0, NO_WANT},
        '{ROW_CFG, cfq_pkg::OP_PUSH,  32'h0,        8'd1,   1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_POP,   32'h0,        8'd0,   1'b1,
          '{1'b0, 32'h0,        7'd0, 1'b1, 1'b0}},
        '{ROW_CFG, cfq_pkg::OP_PUSH,  32'h0,        8'd129, 1'b0, NO_WANT},
        '{ROW_OP,  cfq_pkg::OP_CLEAR, 32'h0,        8'd0,   1'b1,
          '{1'b1, 32'h0,        7'd0, 1'b1, 1'b0}}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [cfq_pkg::CFG_W-1:0] cfg_data;

    cfq_req_if req_ch ();
    cfq_rsp_if rsp_ch ();

    circular_fifo_queue #(
        .MAX_SLOTS(RING_MAX)
    ) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch.sink),
        .o_rsp     (rsp_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor copy of the ring.
    logic [cfq_pkg::WORD_W-1:0] ring_words [RING_MAX];
    int                         ring_size;
    int                         head_idx;
    int                         tail_idx;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      burst_left     = 0;
    int      hold_requests  = 0;

    function automatic int ring_next(int idx);
        return (idx + 1 >= ring_size) ? 0 : idx + 1;
    endfunction

    // Advance the predicted ring by one operation and return its response.
    function automatic t_result apply_op(cfq_pkg::t_opcode op,
                                         logic [cfq_pkg::WORD_W-1:0] value);
        t_result res;
        int      level;
        res = '0;
        case (op)
            cfq_pkg::OP_PUSH: begin
                if (ring_next(tail_idx) != head_idx) begin
                    ring_words[tail_idx] = value;
                    tail_idx = ring_next(tail_idx);
                    res.success = 1'b1;
                end
            end
            cfq_pkg::OP_POP: begin
                if (head_idx != tail_idx) begin
                    res.read_value = ring_words[head_idx];
                    head_idx = ring_next(head_idx);
                    res.success = 1'b1;
                end
            end
            cfq_pkg::OP_PEEK: begin
                if (head_idx != tail_idx) begin
                    res.read_value = ring_words[head_idx];
                    res.success = 1'b1;
                end
            end
            default: begin
                head_idx = 0;
                tail_idx = 0;
                res.success = 1'b1;
            end
        endcase
        level = (tail_idx >= head_idx) ? tail_idx - head_idx : tail_idx + ring_size - head_idx;
        res.occupancy = level[cfq_pkg::OCC_W-1:0];
        res.is_empty  = (head_idx == tail_idx);
        res.is_full   = (ring_next(tail_idx) == head_idx);
        return res;
    endfunction

    // Offer one item in bursts with random gaps; predict once it is accepted.
    task automatic send_item(cfq_pkg::t_opcode op, logic [cfq_pkg::WORD_W-1:0] value,
                             logic has_want, t_result want);
        t_result predicted;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(8, 24);
            else
                gap = $urandom_range(1, 4);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.push_value <= value;
        do @(posedge clk); while (!req_ch.ready);
        predicted = apply_op(op, value);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // Stop offering and wait for every outstanding response.
    task automatic drain_results();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d responses never arrived", pending_results.size());
            mismatch_count += pending_results.size();
            pending_results.delete();
        end
    endtask

    // Write the slot count on an idle block; the write also empties the ring.
    task automatic write_slot_count(logic [cfq_pkg::CFG_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value < 2)
            ring_size = 2;
        else if (value > RING_MAX)
            ring_size = RING_MAX;
        else
            ring_size = value;
        head_idx = 0;
        tail_idx = 0;
    endtask

    task automatic check_field(string name, logic [cfq_pkg::WORD_W-1:0] want,
                               logic [cfq_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("response with no item outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("success", 32'(want.success), 32'(rsp_ch.success));
                check_field("read_value", want.read_value, rsp_ch.read_value);
                check_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
                check_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
                check_field("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
            end
        end
    end

    // Drop ready on a rotating pattern; hold it low for a long stretch on request.
    initial begin : rsp_sink
        int          hold_left;
        int          served;
        int          age;
        int          bit_idx;
        logic [15:0] pattern;
        hold_left = 0;
        served    = 0;
        age       = 0;
        bit_idx   = 0;
        pattern   = '1;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != served) begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (age == 0) begin
                age = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0:       pattern = '1;
                    1:       pattern = 16'($urandom);
                    2:       pattern = 16'($urandom) | 16'($urandom);
                    default: pattern = 16'($urandom) & 16'($urandom);
                endcase
                if (pattern == '0)
                    pattern = 16'h0001;
            end
            age--;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= pattern[bit_idx];
            end
            bit_idx = (bit_idx + 1) % 16;
        end
    end

    // Bound the run.
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        logic [cfq_pkg::CFG_W-1:0] phase_slots [NUM_PHASES];
        int                        items_left;
        int                        seg_left;
        int                        push_pct;
        cfq_pkg::t_opcode          op;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= cfq_pkg::OP_PUSH;
        req_ch.push_value <= '0;
        ring_size = RING_MAX;
        head_idx  = 0;
        tail_idx  = 0;
        phase_slots = '{8'd128, 8'd3, 8'd255, 8'd0, 8'd129, 8'd1, 8'd64, 8'd127};
        phase_slots[6] = cfq_pkg::CFG_W'($urandom_range(2, 127));
        phase_slots[7] = cfq_pkg::CFG_W'($urandom_range(0, 255));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_slot_count(DIRECTED[r].cfg_value);
            else
                send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].has_want,
                          DIRECTED[r].want);
        end

        // Random phases, one slot count each; segments lean toward filling or draining, or stay balanced.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_slot_count(phase_slots[ph]);
            if (ph % 4 == 0)
                hold_requests <= hold_requests + 1;
            items_left = PHASE_ITEMS;
            seg_left   = 0;
            push_pct   = 50;
            while (items_left > 0) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 180);
                    case ($urandom_range(0, 2))
                        0:       push_pct = 90;
                        1:       push_pct = 50;
                        default: push_pct = 15;
                    endcase
                end
                if ($urandom_range(0, 127) == 0)
                    op = cfq_pkg::OP_CLEAR;
                else if ($urandom_range(0, 99) < push_pct)
                    op = cfq_pkg::OP_PUSH;
                else if ($urandom_range(0, 3) == 0)
                    op = cfq_pkg::OP_PEEK;
                else
                    op = cfq_pkg::OP_POP;
                send_item(op, $urandom, 1'b0, NO_WANT);
                seg_left--;
                items_left--;
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
